// File: sv/bdq_pkg.sv
// Shared types, operation codes and port widths for the bounded deque.
package bdq_pkg;

  // Fixed widths of the channel fields
  localparam int OP_W      = 3;
  localparam int PORT_WORD = 32;
  localparam int PORT_CNT  = 5;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  // Operation codes carried by each input transaction
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

  // Controller to datapath
  typedef struct packed {
    logic exec;       // input transaction accepted this cycle
    logic load_read;  // ring read data is valid, move it to the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_read; // offered operation reads an entry of the ring
  } stat_t;

endpackage

// File: sv/bdq_ctrl.sv
// Controller: handshake sequencing and result valid for the bounded deque.
module bdq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  bdq_pkg::stat_t stat,
  output bdq_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  // Result slot is free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign accept   = (state_r == ST_IDLE) && in_valid && out_free;
  assign in_stall = !((state_r == ST_IDLE) && out_free);

  // Next state and result valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.exec      = 1'b0;
    cmd.load_read = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.exec = 1'b1;
          if (stat.needs_read) begin
            state_nxt     = ST_READ;
            out_valid_nxt = 1'b0;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        // slot was freed on accept, so the result always loads here
        cmd.load_read = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: sv/bdq_datapath.sv
// Datapath: ring memory, front pointer, occupancy, capacity and result register.
module bdq_datapath #(
  parameter int DEPTH     = bdq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = bdq_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bdq_pkg::PORT_CNT-1:0]   cfg_capacity_limit,
  input  logic [bdq_pkg::OP_W-1:0]       in_operation,
  input  logic [bdq_pkg::PORT_WORD-1:0]  in_push_word,
  input  bdq_pkg::cmd_t                  cmd,
  output bdq_pkg::stat_t                 stat,
  output logic                           out_accepted,
  output logic [bdq_pkg::PORT_WORD-1:0]  out_read_word,
  output logic                           out_is_empty,
  output logic                           out_is_full,
  output logic [bdq_pkg::PORT_CNT-1:0]   out_entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int PORT_PAD = bdq_pkg::PORT_WORD;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);

  logic [WORD_BITS-1:0] ring_mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [CW-1:0] cap_r, cap_nxt;

  logic [AW-1:0] front_inc, front_dec, back_slot, last_slot, wr_addr, rd_addr;
  logic [SW-1:0] back_sum, last_sum;
  logic          room, nonempty, ok, wr_en, rd_en;

  logic [WORD_BITS+PORT_PAD-1:0] push_ext;
  logic [WORD_BITS+PORT_PAD-1:0] read_ext;
  logic [CW+bdq_pkg::PORT_CNT-1:0] cnt_ext;

  // Slot arithmetic, wrapped by one compare and subtract
  assign front_inc = (front_r == LAST_SLOT) ? '0 : front_r + AW'(1);
  assign front_dec = (front_r == '0) ? LAST_SLOT : front_r - AW'(1);
  assign back_sum  = SW'(front_r) + SW'(occ_r);
  assign last_sum  = SW'(front_r) + SW'(occ_r) - SW'(1);
  assign back_slot = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
  assign last_slot = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);

  assign room     = occ_r < cap_r;
  assign nonempty = occ_r != '0;

  // Operation decode
  always_comb begin
    front_nxt = front_r;
    occ_nxt   = occ_r;
    ok        = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    wr_addr   = back_slot;
    rd_addr   = front_r;
    case (in_operation)
      bdq_pkg::OP_PUSH_BACK: begin
        if (room) begin
          wr_en   = 1'b1;
          occ_nxt = occ_r + CW'(1);
          ok      = 1'b1;
        end
      end
      bdq_pkg::OP_PUSH_FRONT: begin
        if (room) begin
          wr_en     = 1'b1;
          wr_addr   = front_dec;
          front_nxt = front_dec;
          occ_nxt   = occ_r + CW'(1);
          ok        = 1'b1;
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (nonempty) begin
          rd_en     = 1'b1;
          front_nxt = front_inc;
          occ_nxt   = occ_r - CW'(1);
          ok        = 1'b1;
        end
      end
      bdq_pkg::OP_POP_BACK: begin
        if (nonempty) begin
          rd_en   = 1'b1;
          rd_addr = last_slot;
          occ_nxt = occ_r - CW'(1);
          ok      = 1'b1;
        end
      end
      bdq_pkg::OP_PEEK_FRONT: begin
        if (nonempty) begin
          rd_en = 1'b1;
          ok    = 1'b1;
        end
      end
      bdq_pkg::OP_CLEAR: begin
        front_nxt = '0;
        occ_nxt   = '0;
        ok        = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign stat.needs_read = rd_en;

  // Capacity clamp into 1..DEPTH
  always_comb begin
    if (cfg_capacity_limit == '0) begin
      cap_nxt = CW'(1);
    end else if (32'(cfg_capacity_limit) > DEPTH) begin
      cap_nxt = CW'(DEPTH);
    end else begin
      cap_nxt = CW'(cfg_capacity_limit);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      occ_r   <= '0;
      cap_r   <= CW'(DEPTH);
    end else begin
      if (cmd.exec) begin
        front_r <= front_nxt;
        occ_r   <= occ_nxt;
      end
      if (cfg_wr_en) begin
        cap_r <= cap_nxt;
      end
    end
  end

  // Payload width adaptation
  assign push_ext = {{WORD_BITS{1'b0}}, in_push_word};
  assign read_ext = {{PORT_PAD{1'b0}}, rd_data_r};
  assign cnt_ext  = {{bdq_pkg::PORT_CNT{1'b0}}, occ_nxt};

  // Ring memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      ring_mem[wr_addr] <= push_ext[WORD_BITS-1:0];
    end
    if (cmd.exec && rd_en) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  // Result register: status on accept, read word when the ring answers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_accepted    <= ok;
      out_is_empty    <= occ_nxt == '0;
      out_is_full     <= occ_nxt >= cap_r;
      out_entry_count <= cnt_ext[bdq_pkg::PORT_CNT-1:0];
      out_read_word   <= '0;
    end else if (cmd.load_read) begin
      out_read_word   <= read_ext[bdq_pkg::PORT_WORD-1:0];
    end
  end

endmodule

// File: sv/bounded_double_ended_queue.sv
// Top level of the bounded double-ended queue: controller, datapath, checks.
// Usage:
//   Input channel in_valid/in_stall carries one operation (push back, push
//   front, pop front, pop back, peek front, clear) and a push word. Every
//   transaction yields exactly one result transaction on out_valid/out_stall:
//   accepted flag, word read, empty, full and entry count after the operation.
//   cfg_wr_en with cfg_capacity_limit sets the capacity (clamped to 1..DEPTH);
//   write it only while the block is idle.
// Sequencing:
//   Pushes, clear, refused and unknown operations: result valid the cycle
//   after acceptance, one transaction per cycle unless out_stall holds a result.
//   Successful pops and peeks: the word is read into rd_data_r, then loaded
//   into the result register in state ST_READ; in_stall is high in ST_READ,
//   so no new transaction is taken before that result is loaded.
// Reset: synchronous, active low; the queue empties, the front pointer goes
//   to slot 0 and the capacity returns to DEPTH.
// Stall: a waiting result is held in the output register; a new transaction
//   is still taken in the cycle the result leaves, otherwise in_stall rises.
module bounded_double_ended_queue #(
  parameter int DEPTH     = bdq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = bdq_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bdq_pkg::PORT_CNT-1:0]   cfg_capacity_limit,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bdq_pkg::OP_W-1:0]       in_operation,
  input  logic [bdq_pkg::PORT_WORD-1:0]  in_push_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_accepted,
  output logic [bdq_pkg::PORT_WORD-1:0]  out_read_word,
  output logic                           out_is_empty,
  output logic                           out_is_full,
  output logic [bdq_pkg::PORT_CNT-1:0]   out_entry_count
);

  bdq_pkg::cmd_t  cmd;
  bdq_pkg::stat_t stat;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bdq_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_capacity_limit (cfg_capacity_limit),
    .in_operation       (in_operation),
    .in_push_word       (in_push_word),
    .cmd                (cmd),
    .stat               (stat),
    .out_accepted       (out_accepted),
    .out_read_word      (out_read_word),
    .out_is_empty       (out_is_empty),
    .out_is_full        (out_is_full),
    .out_entry_count    (out_entry_count)
  );

  // Read data only ever lands in an empty result slot
  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_read |-> !out_valid)
    else $error("ring read data arrived while a result was pending");

  // A reading operation is followed by the read data load
  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && stat.needs_read) |=> cmd.load_read)
    else $error("read operation did not complete in the next cycle");

  // Non-reading operations present their result the next cycle
  a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && !stat.needs_read) |=> out_valid)
    else $error("result missing after a non-reading operation");

  // A refused operation reads nothing
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |-> (out_read_word == '0))
    else $error("refused transaction carries a read word");

endmodule
